### rtl/core/lsct_pkg.sv
// Package for the LRU slice cache tag list: modes, result kinds and the work
// descriptor that travels from the front part to the back part.
// No dependencies.
`default_nettype none
package lsct_pkg;
    localparam int unsigned MODE_BITS = 3;
    localparam int unsigned CFG_BITS  = 5;

    typedef enum logic [2:0] {
        MODE_PROBE   = 3'd0,
        MODE_LOOKUP  = 3'd1,
        MODE_INS_FIN = 3'd2,
        MODE_INS_UNF = 3'd3,
        MODE_CLEAR   = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        OP_SEARCH,
        OP_PARK,
        OP_INSERT,
        OP_CLEAR,
        OP_NONE
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_EVICT,
        ST_CLEAR,
        ST_STATUS
    } t_state;

    localparam logic KIND_STATUS  = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;
endpackage
`default_nettype wire

### rtl/core/lsct_front.sv
// Front part: accepts items, classifies the mode into an operation and holds
// them in a short queue for the back part. Depends on lsct_pkg.
`default_nettype none
module lsct_front #(
    parameter int KEY_BITS    = 32,
    parameter int HANDLE_BITS = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   push,
    output logic                        full,
    input  wire logic [2:0]             i_mode,
    input  wire logic [KEY_BITS-1:0]    i_key,
    input  wire logic [HANDLE_BITS-1:0] i_payload,
    input  wire logic                   i_size_zero,
    input  wire logic                   i_take,
    output logic                        o_avail,
    output lsct_pkg::t_op               o_op,
    output logic                        o_move,
    output logic [KEY_BITS-1:0]         o_key,
    output logic [HANDLE_BITS-1:0]      o_handle
);
    import lsct_pkg::*;

    t_op                  r_op   [2];
    logic                 r_move [2];
    logic [KEY_BITS-1:0]  r_key  [2];
    logic [HANDLE_BITS-1:0] r_hdl [2];
    logic                 r_wp, r_rp;
    logic [1:0]           r_cnt;
    t_op                  n_op;
    logic                 wr, rd;

    // The size-zero check is made when the item is taken by the back part.
    always_comb begin
        case (i_mode)
            MODE_PROBE, MODE_LOOKUP: n_op = OP_SEARCH;
            MODE_INS_FIN:            n_op = OP_INSERT;
            MODE_INS_UNF:            n_op = OP_PARK;
            MODE_CLEAR:              n_op = OP_CLEAR;
            default:                 n_op = OP_NONE;
        endcase
    end

    assign full    = (r_cnt == 2'd2);
    assign wr      = push && !full;
    assign o_avail = (r_cnt != 2'd0);
    assign rd      = i_take && o_avail;

    always_comb begin
        o_op     = r_op[r_rp];
        if (r_op[r_rp] == OP_INSERT && i_size_zero) begin
            o_op = OP_PARK;
        end
        o_move   = r_move[r_rp];
        o_key    = r_key[r_rp];
        o_handle = r_hdl[r_rp];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) begin
                r_wp <= !r_wp;
            end
            if (rd) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_op[r_wp]   <= n_op;
            r_move[r_wp] <= (i_mode == MODE_LOOKUP);
            r_key[r_wp]  <= i_key;
            r_hdl[r_wp]  <= i_payload;
        end
    end
endmodule
`default_nettype wire

### rtl/core/lsct_back.sv
// Back part: the tag list, side slot and sequencer that carries out one
// operation and emits its results into a two-entry output queue.
// Depends on lsct_pkg.
`default_nettype none
module lsct_back #(
    parameter int DEPTH       = 16,
    parameter int KEY_BITS    = 32,
    parameter int HANDLE_BITS = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [4:0]             i_cfg_data,
    output logic                        o_size_zero,
    input  wire logic                   i_avail,
    output logic                        o_take,
    input  lsct_pkg::t_op               i_op,
    input  wire logic                   i_move,
    input  wire logic [KEY_BITS-1:0]    i_key,
    input  wire logic [HANDLE_BITS-1:0] i_handle,
    output logic                        empty,
    input  wire logic                   pop,
    output logic                        o_kind,
    output logic                        o_hit,
    output logic [HANDLE_BITS-1:0]      o_handle,
    output logic                        o_last
);
    import lsct_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int RW = HANDLE_BITS + 3;

    logic [KEY_BITS-1:0]    r_keys [DEPTH];
    logic [HANDLE_BITS-1:0] r_hdls [DEPTH];
    logic [CW-1:0]          r_count, n_count;
    logic [CW-1:0]          r_size;
    logic [KEY_BITS-1:0]    r_side_key;
    logic [HANDLE_BITS-1:0] r_side_hdl;
    logic                   r_side_valid;
    t_state                 r_state, n_state;
    logic                   r_move, r_hit, n_hit;
    logic [HANDLE_BITS-1:0] r_fh, n_fh;
    logic [KEY_BITS-1:0]    r_key;
    logic [CW-1:0]          r_idx, n_idx;
    logic [DEPTH-1:0]       match;
    logic [IW-1:0]          midx;
    logic                   mfound;
    logic [CW-1:0]          cfg_eff;

    logic [RW-1:0] r_q [2];
    logic          r_qw, r_qr;
    logic [1:0]    r_qc;
    logic          q_push, q_pop, q_room;
    logic [RW-1:0] q_din;

    logic          shift_ins, shift_mtf, park;

    assign cfg_eff = ({{(CW > 5 ? CW-5 : 0){1'b0}}, i_cfg_data} > CW'(DEPTH))
                   ? CW'(DEPTH) : CW'(i_cfg_data);
    assign o_size_zero = (r_size == '0);

    assign q_pop  = pop && !empty;
    assign empty  = (r_qc == 2'd0);
    assign q_room = (r_qc != 2'd2) || q_pop;
    assign {o_kind, o_hit, o_handle, o_last} = r_q[r_qr];

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            match[i] = (r_keys[i] == r_key) && (CW'(i) < r_count);
        end
        midx   = '0;
        mfound = 1'b0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (match[i]) begin
                midx   = IW'(i);
                mfound = 1'b1;
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_hit     = r_hit;
        n_fh      = r_fh;
        o_take    = 1'b0;
        q_push    = 1'b0;
        q_din     = '0;
        shift_ins = 1'b0;
        shift_mtf = 1'b0;
        park      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_avail) begin
                    case (i_op)
                        OP_SEARCH: begin
                            o_take  = 1'b1;
                            n_state = ST_SEARCH;
                        end
                        OP_PARK: begin
                            if (q_room) begin
                                o_take = 1'b1;
                                park   = 1'b1;
                                n_hit  = 1'b0;
                                n_fh   = '0;
                                if (r_side_valid) begin
                                    q_push  = 1'b1;
                                    q_din   = {KIND_RELEASE, 1'b0, r_side_hdl, 1'b0};
                                end
                                n_state = ST_STATUS;
                            end
                        end
                        OP_INSERT: begin
                            if (r_count == CW'(DEPTH)) begin
                                if (q_room) begin
                                    q_push  = 1'b1;
                                    q_din   = {KIND_RELEASE, 1'b0, r_hdls[DEPTH-1], 1'b0};
                                    n_count = r_count - 1'b1;
                                end
                            end else begin
                                o_take    = 1'b1;
                                shift_ins = 1'b1;
                                n_count   = r_count + 1'b1;
                                n_hit     = 1'b0;
                                n_fh      = '0;
                                n_state   = ST_EVICT;
                            end
                        end
                        OP_CLEAR: begin
                            o_take  = 1'b1;
                            n_idx   = '0;
                            n_hit   = 1'b0;
                            n_fh    = '0;
                            n_state = ST_CLEAR;
                        end
                        default: begin
                            o_take  = 1'b1;
                            n_hit   = 1'b0;
                            n_fh    = '0;
                            n_state = ST_STATUS;
                        end
                    endcase
                end
            end
            ST_SEARCH: begin
                n_hit = mfound;
                n_fh  = mfound ? r_hdls[midx] : '0;
                if (mfound && r_move) begin
                    shift_mtf = 1'b1;
                end
                n_state = ST_STATUS;
            end
            ST_EVICT: begin
                if (r_count > r_size) begin
                    if (q_room) begin
                        q_push  = 1'b1;
                        q_din   = {KIND_RELEASE, 1'b0, r_hdls[IW'(r_count - 1'b1)], 1'b0};
                        n_count = r_count - 1'b1;
                    end
                end else begin
                    n_state = ST_STATUS;
                end
            end
            ST_CLEAR: begin
                if (r_idx < r_count) begin
                    if (q_room) begin
                        q_push = 1'b1;
                        q_din  = {KIND_RELEASE, 1'b0, r_hdls[IW'(r_idx)], 1'b0};
                        n_idx  = r_idx + 1'b1;
                    end
                end else begin
                    n_count = '0;
                    n_state = ST_STATUS;
                end
            end
            ST_STATUS: begin
                if (q_room) begin
                    q_push  = 1'b1;
                    q_din   = {KIND_STATUS, r_hit, r_fh, 1'b1};
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_count      <= '0;
            r_size       <= CW'(DEPTH);
            r_side_valid <= 1'b0;
            r_side_key   <= '0;
            r_side_hdl   <= '0;
            r_qw         <= 1'b0;
            r_qr         <= 1'b0;
            r_qc         <= 2'd0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg_we) begin
                r_size <= cfg_eff;
                if (r_count > cfg_eff) begin
                    r_count <= cfg_eff;
                end
            end
            if (park) begin
                r_side_valid <= 1'b1;
                r_side_key   <= i_key;
                r_side_hdl   <= i_handle;
            end
            if (q_push) begin
                r_qw <= !r_qw;
            end
            if (q_pop) begin
                r_qr <= !r_qr;
            end
            r_qc <= r_qc + {1'b0, q_push} - {1'b0, q_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_hit <= n_hit;
        r_fh  <= n_fh;
        if (o_take) begin
            r_key  <= i_key;
            r_move <= i_move;
        end
        if (q_push) begin
            r_q[r_qw] <= q_din;
        end
        if (shift_ins) begin
            r_keys[0] <= i_key;
            r_hdls[0] <= i_handle;
            for (int i = 1; i < DEPTH; i++) begin
                r_keys[i] <= r_keys[i-1];
                r_hdls[i] <= r_hdls[i-1];
            end
        end else if (shift_mtf) begin
            r_keys[0] <= r_keys[midx];
            r_hdls[0] <= r_hdls[midx];
            for (int i = 1; i < DEPTH; i++) begin
                if (IW'(i) <= midx) begin
                    r_keys[i] <= r_keys[i-1];
                    r_hdls[i] <= r_hdls[i-1];
                end
            end
        end
    end
endmodule
`default_nettype wire

### rtl/core/lru_slice_cache_tags_top.sv
// Top level of the LRU slice cache tag list: front queue and back sequencer.
// Depends on lsct_pkg, lsct_front and lsct_back.
//
//   channel   handshake          payload
//   input     push / full        i_mode, i_key, i_payload
//   result    empty / pop        o_kind, o_hit, o_handle, o_last
//   config    i_cfg_we           i_cfg_data (cache size)
//
// A probe or lookup searches the list, and an insert that parks in the side
// slot or an unused mode goes straight to status. An insert into the list
// or a clear also emits one release per freed handle, the one released
// from a full list included. The two-entry item queue lets pushes continue
// while the sequencer works; a full result queue stalls the sequencer. Reset
// empties the list and side slot and sets the size to DEPTH.
`default_nettype none
module lru_slice_cache_tags_top #(
    parameter int DEPTH       = 16,
    parameter int KEY_BITS    = 32,
    parameter int HANDLE_BITS = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   push,
    output logic                        full,
    input  wire logic [2:0]             i_mode,
    input  wire logic [KEY_BITS-1:0]    i_key,
    input  wire logic [HANDLE_BITS-1:0] i_payload,
    input  wire logic                   i_cfg_we,
    input  wire logic [4:0]             i_cfg_data,
    output logic                        empty,
    input  wire logic                   pop,
    output logic                        o_kind,
    output logic                        o_hit,
    output logic [HANDLE_BITS-1:0]      o_handle,
    output logic                        o_last
);
    import lsct_pkg::*;

    logic                   size_zero, avail, take, move;
    t_op                    op;
    logic [KEY_BITS-1:0]    key;
    logic [HANDLE_BITS-1:0] hdl;

    lsct_front #(.KEY_BITS(KEY_BITS), .HANDLE_BITS(HANDLE_BITS)) u_front (
        .i_clk, .i_rst_n, .push, .full, .i_mode, .i_key, .i_payload,
        .i_size_zero(size_zero), .i_take(take), .o_avail(avail), .o_op(op),
        .o_move(move), .o_key(key), .o_handle(hdl)
    );

    lsct_back #(.DEPTH(DEPTH), .KEY_BITS(KEY_BITS), .HANDLE_BITS(HANDLE_BITS)) u_back (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_data, .o_size_zero(size_zero),
        .i_avail(avail), .o_take(take), .i_op(op), .i_move(move), .i_key(key),
        .i_handle(hdl), .empty, .pop, .o_kind, .o_hit, .o_handle, .o_last
    );
endmodule
`default_nettype wire
